>>> hdl/aob_pkg.sv
`default_nettype none

package aob_pkg;

    // Widths of the fixed-point composite.
    localparam int PIX_W  = 8;
    localparam int NCH    = 3;
    localparam int DEN_W  = 16;  // wf + wb never exceeds 255 * 255
    localparam int NUM_W  = 24;  // cf * wf + cb * wb never exceeds 255 * 255 * 255
    localparam int QUO_W  = 8;   // a weighted mean of 8-bit values stays below 256

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;

    // One pixel as it moves down the row of divider cells.
    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] rem;
        logic [NCH-1:0][QUO_W-1:0] quo;
        logic [DEN_W-1:0]          den;
        logic [PIX_W-1:0]          alpha;
        logic                      zero;
    } t_div_word;

endpackage

`default_nettype wire

>>> hdl/aob_prep.sv
`default_nettype none

// Two register stages: the background weight first, then the foreground weight,
// the per-channel numerators, the shared denominator and the output alpha.
module aob_prep (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ce,
    input  wire logic                           i_vld,
    input  wire logic [4*aob_pkg::PIX_W*2-1:0]  i_pix,
    output logic                                o_vld,
    output aob_pkg::t_div_word                  o_word
);

    logic [aob_pkg::NCH-1:0][aob_pkg::PIX_W-1:0] r_fg;
    logic [aob_pkg::NCH-1:0][aob_pkg::PIX_W-1:0] r_bg;
    logic [aob_pkg::PIX_W-1:0]                   r_fa;
    logic [aob_pkg::DEN_W-1:0]                   r_wb;
    logic                                        r_vld_a;
    logic                                        r_vld_b;
    aob_pkg::t_div_word                          r_word;
    aob_pkg::t_div_word                          n_word;

    logic [aob_pkg::PIX_W-1:0] w_ba;
    logic [aob_pkg::PIX_W-1:0] w_fa;

    assign w_fa = i_pix[31:24];
    assign w_ba = i_pix[63:56];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                r_fg[c] <= i_pix[c*8 +: 8];
                r_bg[c] <= i_pix[32 + c*8 +: 8];
            end
            r_fa <= w_fa;
            r_wb <= aob_pkg::DEN_W'(w_ba) * aob_pkg::DEN_W'(aob_pkg::PIX_MAX - w_fa);
        end
    end

    always_comb begin
        logic [aob_pkg::DEN_W-1:0] wf;
        logic [aob_pkg::DEN_W-1:0] t;
        wf = {r_fa, 8'h00} - {8'h00, r_fa};
        // floor(wb / 255) by reciprocal; exact for wb up to 255 * 255.
        t  = r_wb + {8'h00, r_wb[15:8]} + 16'd1;
        for (int c = 0; c < aob_pkg::NCH; c++) begin
            n_word.rem[c] = aob_pkg::NUM_W'(r_fg[c]) * aob_pkg::NUM_W'(wf)
                          + aob_pkg::NUM_W'(r_bg[c]) * aob_pkg::NUM_W'(r_wb);
            n_word.quo[c] = '0;
        end
        n_word.den   = wf + r_wb;
        n_word.alpha = r_fa + t[15:8];
        n_word.zero  = (wf == '0) && (r_wb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_ce) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_word = r_word;

endmodule

`default_nettype wire

>>> hdl/aob_div_cell.sv
`default_nettype none

// One restoring-division step: decides quotient bit BIT for all three channels
// against the shared denominator and passes the pixel to the next cell.
module aob_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ce,
    input  wire logic               i_vld,
    input  wire aob_pkg::t_div_word i_word,
    output logic                    o_vld,
    output aob_pkg::t_div_word      o_word
);

    aob_pkg::t_div_word r_word;
    aob_pkg::t_div_word n_word;
    logic               r_vld;

    always_comb begin
        logic [aob_pkg::NUM_W:0] diff;
        n_word = i_word;
        for (int c = 0; c < aob_pkg::NCH; c++) begin
            diff = {1'b0, i_word.rem[c]}
                 - ((aob_pkg::NUM_W+1)'(i_word.den) << BIT);
            if (!diff[aob_pkg::NUM_W]) begin
                n_word.rem[c]      = diff[aob_pkg::NUM_W-1:0];
                n_word.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

`default_nettype wire

>>> hdl/aob_out_skid.sv
`default_nettype none

// Output register with one skid entry, so the pipeline upstream sees a
// registered ready.
module aob_out_skid (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_data,
    output logic             o_ready,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata
);

    logic        r_out_vld;
    logic [31:0] r_out;
    logic        r_skid_vld;
    logic [31:0] r_skid;
    logic        w_in;
    logic        w_free;

    assign w_in   = i_vld && !r_skid_vld;
    assign w_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_free) begin
            r_out_vld  <= r_skid_vld || w_in;
            r_skid_vld <= 1'b0;
        end else if (w_in) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (w_in) begin
            r_skid <= i_data;
        end
    end

    assign o_ready    = !r_skid_vld;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

>>> hdl/alpha_over_blend.sv
`default_nettype none

// Porter-Duff "over" composite of two straight-alpha RGBA8 pixels.
// The slave channel carries one foreground/background pixel pair per transfer,
// the master channel one composited RGBA8 pixel per transfer, in the same order.
// Output alpha is fa + floor(ba*(255-fa)/255); each color channel is the exact
// floor of the alpha-weighted mean of the two input colors. When both input
// alphas are zero the whole result is zero.
// An input transfer passes through two preparation stages (weights, then
// numerators and denominator), eight divider cells that each settle one
// quotient bit for all three channels, and the output register. One pixel
// pair is taken every clock while the skid entry is empty.
// The row of divider cells advances as long as the skid entry behind it is
// empty. When the receiver stalls, the output register holds its pixel, the
// next finished pixel parks in the skid entry, and the slave ready drops once
// that entry is full; the row then freezes until the receiver takes a transfer.
// Synchronous active-low reset clears all valid flags; the block comes out of
// reset empty and ready, and no result is lost or repeated across a stall.
module alpha_over_blend (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // fg_red, fg_green, fg_blue, fg_alpha, bg_red, bg_green, bg_blue, bg_alpha
    input  wire logic [63:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]      o_m_axis_tdata
);

    localparam int NCELL = aob_pkg::QUO_W;

    logic               w_ce;
    logic               w_vld  [NCELL+1];
    aob_pkg::t_div_word w_word [NCELL+1];
    logic [31:0]        w_pix;

    // The whole row moves together; it stops only while the skid entry is full.
    assign o_s_axis_tready = w_ce;

    aob_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (i_s_axis_tvalid),
        .i_pix   (i_s_axis_tdata),
        .o_vld   (w_vld[0]),
        .o_word  (w_word[0])
    );

    // The first cell settles the most significant quotient bit.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        aob_div_cell #(
            .BIT (NCELL - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_vld   (w_vld[g]),
            .i_word  (w_word[g]),
            .o_vld   (w_vld[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    // With both alphas zero the division is meaningless, so the colors are forced to zero.
    always_comb begin
        for (int c = 0; c < aob_pkg::NCH; c++) begin
            w_pix[c*8 +: 8] = w_word[NCELL].zero ? '0 : w_word[NCELL].quo[c];
        end
        w_pix[31:24] = w_word[NCELL].alpha;
    end

    aob_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_vld[NCELL]),
        .i_data     (w_pix),
        .o_ready    (w_ce),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/aob_checker.sv
`default_nettype none

module aob_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [63:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata
);

    // A pending result is never withdrawn.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A transparent result carries no color.
    a_clear_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[31:24] == 8'h00)
        |-> (o_m_axis_tdata[23:0] == 24'h000000))
        else $error("zero alpha with nonzero color");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // Reset leaves the block able to take a pixel pair.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind alpha_over_blend aob_checker u_aob_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> bench/alpha_over_blend_tb.sv
`default_nettype none

// Self-checking bench for the straight-alpha "over" compositor.
// An initial block builds the whole list of pixel pairs up front: a short
// directed set, then random pairs. A clocked driver offers the pairs on the
// slave channel. A clocked monitor takes composites off the master channel.
// Every accepted pair is run through a local integer model of the composite,
// and the expected pixel is queued. Each composite that leaves the block is
// compared, channel by channel, with the oldest queued pixel.
module alpha_over_blend_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The fields are listed from the top bits down, so the packed value matches
    // the port layout: fg_red sits in the lowest byte and bg_alpha in the highest.
    typedef struct packed {
        logic [7:0] bg_alpha;
        logic [7:0] bg_blue;
        logic [7:0] bg_green;
        logic [7:0] bg_red;
        logic [7:0] fg_alpha;
        logic [7:0] fg_blue;
        logic [7:0] fg_green;
        logic [7:0] fg_red;
    } t_pixel_pair;

    // Composite pixel: out_red in the lowest byte, out_alpha in the highest.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    // A pair waiting to be sent, with the idle cycles the sender spends after
    // it and a flag that makes the sender wait for the pipeline to drain first.
    typedef struct {
        t_pixel_pair pair;
        int unsigned gap;
        bit          drain_first;
    } t_pending_pair;

    localparam int unsigned RANDOM_PAIRS = 850;
    // The receiver holds off for a long stretch after this many composites.
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned HOLD_CYCLES  = 200;
    // Pairs sent back to back around the long hold, so the block fills up.
    localparam int unsigned BURST_FIRST  = 280;
    localparam int unsigned BURST_LAST   = 380;
    // The sender waits for every composite to arrive before this pair.
    localparam int unsigned DRAIN_AT     = 620;
    // Covers the pipeline registers plus a skid entry with room to spare.
    localparam int unsigned SETTLE_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;

    t_pending_pair pair_q[$];   // pairs not yet accepted by the block
    t_rgba         blend_q[$];  // composites the block still owes us

    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned composites_seen;
    int unsigned dir_count;
    bit          mismatch_seen;

    alpha_over_blend dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor of the weighted mean of two 8-bit colors. With no weight at all
    // (both alphas transparent) the channel is defined as zero.
    function automatic logic [7:0] weighted_mean(input int unsigned cf, input int unsigned cb,
                                                 input int unsigned wf, input int unsigned wb);
        int unsigned den;
        int unsigned q;
        den = wf + wb;
        if (den == 0) begin
            return 8'd0;
        end
        q = (cf * wf + cb * wb) / den;
        return (q > aob_pkg::PIX_MAX) ? aob_pkg::PIX_MAX : q[7:0];
    endfunction

    // The over composite in exact integers. Both weights are scaled by 255*255:
    // the foreground counts fa*255, the background ba*(255-fa).
    function automatic t_rgba composite_over(input t_pixel_pair p);
        t_rgba       r;
        int unsigned fa;
        int unsigned wf;
        int unsigned wb;
        int unsigned oa;
        fa = p.fg_alpha;
        wf = fa * aob_pkg::PIX_MAX;
        wb = p.bg_alpha * (aob_pkg::PIX_MAX - fa);
        oa = fa + wb / aob_pkg::PIX_MAX;
        r.red   = weighted_mean(p.fg_red,   p.bg_red,   wf, wb);
        r.green = weighted_mean(p.fg_green, p.bg_green, wf, wb);
        r.blue  = weighted_mean(p.fg_blue,  p.bg_blue,  wf, wb);
        r.alpha = (oa > aob_pkg::PIX_MAX) ? aob_pkg::PIX_MAX : oa[7:0];
        return r;
    endfunction

    // Alphas are drawn with extra weight on the edges of the range, where the
    // opaque and transparent special cases live.
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_pair(input t_pixel_pair p, input int unsigned idx);
        t_pending_pair e;
        e.pair = p;
        // Idle phases alternate with stretches of back-to-back transfers.
        if ((idx >= BURST_FIRST && idx <= BURST_LAST) || ((idx / 60) % 3 == 0)) begin
            e.gap = 0;
        end else begin
            e.gap = $urandom_range(0, 19);
        end
        e.drain_first = (idx == DRAIN_AT) || (idx == dir_count);
        pair_q.push_back(e);
    endtask

    task automatic add_directed(input logic [31:0] fg, input logic [31:0] bg);
        t_pixel_pair p;
        p = {bg, fg};
        add_pair(p, pair_q.size());
    endtask

    // Driver: offers the head of the pending list. A pair leaves the list
    // only once its transfer has happened, and it is predicted right there.
    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = 1'b0;
        if (!i_rst_n) begin
            send_wait = 0;
            s_valid  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                blend_q.push_back(composite_over(pair_q[0].pair));
                send_wait = pair_q[0].gap;
                void'(pair_q.pop_front());
            end else if (s_valid) begin
                next_valid = 1'b1;  // held until the block takes it
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pair_q.size() != 0 &&
                             !(pair_q[0].drain_first && blend_q.size() != 0)) begin
                    next_valid = 1'b1;
                    s_data <= pair_q[0].pair;
                end
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: takes composites and checks them against the oldest expected
    // pixel. After each transfer it draws how long to stall before the next.
    always @(posedge i_clk) begin
        t_rgba got;
        t_rgba want;
        if (!i_rst_n) begin
            recv_wait = 0;
            m_ready  <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (blend_q.size() == 0) begin
                    $error("composite %h arrived with nothing expected", got);
                    mismatch_seen = 1'b1;
                end else begin
                    want = blend_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("out_red: expected %0d, actual %0d", want.red, got.red);
                        mismatch_seen = 1'b1;
                    end
                    if (got.green !== want.green) begin
                        $error("out_green: expected %0d, actual %0d", want.green, got.green);
                        mismatch_seen = 1'b1;
                    end
                    if (got.blue !== want.blue) begin
                        $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
                        mismatch_seen = 1'b1;
                    end
                    if (got.alpha !== want.alpha) begin
                        $error("out_alpha: expected %0d, actual %0d", want.alpha, got.alpha);
                        mismatch_seen = 1'b1;
                    end
                end
                composites_seen++;
                // One long hold while the sender keeps offering fills the
                // divider row and the skid entry, so the slave ready must drop.
                if (composites_seen == HOLD_AFTER) begin
                    recv_wait = HOLD_CYCLES;
                end else if ((composites_seen / 70) % 3 == 1) begin
                    recv_wait = 0;
                end else begin
                    recv_wait = $urandom_range(0, 19);
                end
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_ready <= (recv_wait == 0);
        end
    end

    initial begin
        t_pixel_pair p;
        i_rst_n       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        mismatch_seen = 1'b0;
        composites_seen = 0;
        dir_count     = 0;

        // Directed pairs. The random part begins with a drain, so the index
        // of its first pair is fixed here before anything is queued.
        dir_count = 16;
        add_directed(32'h0000_0000, 32'h0000_0000);  // everything zero
        add_directed(32'h00ff_ffff, 32'h00ff_ffff);  // both transparent, bright colors
        add_directed(32'h00a5_5a3c, 32'h00c3_1e77);  // both transparent, mixed colors
        add_directed(32'hff12_3456, 32'hff65_4321);  // opaque foreground hides background
        add_directed(32'hff00_0000, 32'h00ff_ffff);  // opaque foreground, clear background
        add_directed(32'h00ab_cdef, 32'hff10_2030);  // clear foreground, opaque background
        add_directed(32'h0011_2233, 32'h8044_5566);  // clear foreground, half background
        add_directed(32'hffff_ffff, 32'hffff_ffff);  // everything at full scale
        add_directed(32'h80ff_ffff, 32'h8000_0000);  // half over half, extreme colors
        add_directed(32'h01ff_ffff, 32'hff00_0000);  // faintest foreground
        add_directed(32'hfe00_0000, 32'h01ff_ffff);  // near-opaque over faint background
        add_directed(32'h7fff_00ff, 32'h0100_ff00);  // background barely present
        add_directed(32'haaaa_aaaa, 32'h5555_5555);  // alternating bit patterns
        add_directed(32'h5555_5555, 32'haaaa_aaaa);
        add_directed(32'h01ff_ffff, 32'h01ff_ffff);  // both nearly clear
        add_directed(32'hfeff_00ff, 32'hfe00_ff00);

        for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
            p = {$urandom(), $urandom()};
            if ($urandom_range(0, 1) == 0) begin
                p.fg_alpha = pick_alpha();
                p.bg_alpha = pick_alpha();
            end
            add_pair(p, pair_q.size());
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every pair has been taken once the list is empty and nothing is
        // being offered; then the pipeline only has to drain.
        while (pair_q.size() != 0 || s_valid || blend_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (blend_q.size() != 0) begin
            $error("%0d composites never arrived", blend_q.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Worst case is roughly 870 pairs with their idle gaps and stalls; this allows
    // several times that.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
